### hw/rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion on the usual clock and reset names
`define ASSERT_STD(lbl, prop) \
   `ASSERT_CLK(lbl, clock, reset, prop)

`endif

### hw/rtl/ldm_pkg.sv
package ldm_pkg;

   localparam int QW     = 20;
   localparam int STAGES = 12;

   localparam logic signed [QW-1:0] Q_MAX = 20'sh7FFFF;
   localparam logic signed [QW-1:0] Q_MIN = 20'sh80000;

   localparam logic [23:0] INV_FOCAL_RESET = 24'd41943;

   typedef enum logic [2:0] {
      CSR_CENTER = 3'd0,
      CSR_INV_FX = 3'd1,
      CSR_INV_FY = 3'd2,
      CSR_K1     = 3'd3,
      CSR_K2     = 3'd4,
      CSR_K3     = 3'd5,
      CSR_P1     = 3'd6,
      CSR_P2     = 3'd7
   } ldm_csr_type;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
   } ldm_req_type;

   typedef struct packed {
      logic signed [QW-1:0] norm_x;
      logic signed [QW-1:0] norm_y;
      logic                 overflow;
   } ldm_rsp_type;

endpackage

### hw/rtl/lens_distortion_model.sv
// Brown-Conrady lens distortion on a stream of pixel coordinates.
// req channel: req_valid / req_stall with req_data (pixel_x, pixel_y, unsigned Q12.4).
// rsp channel: rsp_valid / rsp_stall with rsp_data (norm_x, norm_y signed Q3.16,
// overflow set when a normalized coordinate or a result was saturated).
// csr port: csr_we, csr_index, csr_wdata; write registers only while idle, unchecked by the block.
// A request is taken when req_valid is high and req_stall low, and likewise on rsp.
// The datapath is a 12 stage pipeline with a two-slot output (stage 12 plus one
// skid register). Throughput is one request per cycle while the skid register is
// empty; the result appears on rsp_data from the stage 12 register.
// The depth is set by the chain of multiplications dx*inv_focal, x*x, r2*r2, r4*r2,
// k3*r6 and x*factor, each with a register after it, plus the rounding stages.
// When rsp_stall holds the last result the skid register catches it and the pipeline
// advances once more; while the skid register is full req_stall is high and all
// stages hold. Synchronous reset empties the pipeline and the skid register and
// restores the coefficient registers to their reset values (focal length of 400
// pixels, 41943 in Q0.24, zero centre and coefficients).
module lens_distortion_model
   import ldm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ldm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ldm_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   `include "assert_macros.svh"

   // coefficient registers
   logic [31:0]          center_ff;
   logic [23:0]          ifx_ff, ify_ff;
   logic signed [QW-1:0] k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         ifx_ff    <= INV_FOCAL_RESET;
         ify_ff    <= INV_FOCAL_RESET;
         k1_ff     <= '0;
         k2_ff     <= '0;
         k3_ff     <= '0;
         p1_ff     <= '0;
         p2_ff     <= '0;
      end else if (csr_we) begin
         unique case (ldm_csr_type'(csr_index))
            CSR_CENTER: center_ff <= csr_wdata;
            CSR_INV_FX: ifx_ff    <= csr_wdata[23:0];
            CSR_INV_FY: ify_ff    <= csr_wdata[23:0];
            CSR_K1:     k1_ff     <= csr_wdata[QW-1:0];
            CSR_K2:     k2_ff     <= csr_wdata[QW-1:0];
            CSR_K3:     k3_ff     <= csr_wdata[QW-1:0];
            CSR_P1:     p1_ff     <= csr_wdata[QW-1:0];
            CSR_P2:     p2_ff     <= csr_wdata[QW-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [QW:0] sat_q(input logic signed [47:0] v);
      logic [QW:0] r;
      if (v > 48'(Q_MAX)) begin
         r = {1'b1, Q_MAX};
      end else if (v < 48'(Q_MIN)) begin
         r = {1'b1, Q_MIN};
      end else begin
         r = {1'b0, v[QW-1:0]};
      end
      return r;
   endfunction

   // flow control
   logic               en;
   logic [STAGES-1:0]  vld_ff, vld_in;
   logic               skid_vld_ff, skid_vld_in;
   ldm_rsp_type        skid_data_ff;
   ldm_rsp_type        out_ff, out_in;

   assign en          = !skid_vld_ff;
   assign req_stall   = skid_vld_ff;
   assign vld_in      = {vld_ff[STAGES-2:0], req_valid};
   assign rsp_valid   = skid_vld_ff | vld_ff[STAGES-1];
   assign rsp_data    = skid_vld_ff ? skid_data_ff : out_ff;
   assign skid_vld_in = rsp_stall & rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= vld_in;
         end
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         skid_data_ff <= out_ff;
      end
   end

   // stage 1: centre offset times reciprocal focal length
   logic signed [16:0] dx_c, dy_c;
   logic signed [41:0] mx_ff, my_ff, mx_in, my_in;

   assign dx_c  = $signed({1'b0, req_data.pixel_x}) - $signed({1'b0, center_ff[15:0]});
   assign dy_c  = $signed({1'b0, req_data.pixel_y}) - $signed({1'b0, center_ff[31:16]});
   assign mx_in = dx_c * $signed({1'b0, ifx_ff});
   assign my_in = dy_c * $signed({1'b0, ify_ff});

   // stage 2: round to Q.16 and saturate
   logic signed [41:0]   mxr_c, myr_c;
   logic [QW:0]          satx_c, saty_c;
   logic signed [QW-1:0] x2_ff, y2_ff;
   logic                 ovf2_ff, ovf2_in;

   assign mxr_c   = mx_ff + 42'sd2048;
   assign myr_c   = my_ff + 42'sd2048;
   assign satx_c  = sat_q(48'($signed(mxr_c[41:12])));
   assign saty_c  = sat_q(48'($signed(myr_c[41:12])));
   assign ovf2_in = satx_c[QW] | saty_c[QW];

   // stage 3: squares and cross product
   logic signed [QW-1:0] x3_ff, y3_ff;
   logic                 ovf3_ff;
   logic signed [39:0]   xx_ff, yy_ff, xy_ff, xx_in, yy_in, xy_in;

   assign xx_in = x2_ff * x2_ff;
   assign yy_in = y2_ff * y2_ff;
   assign xy_in = x2_ff * y2_ff;

   // stage 4: round squares, r2
   logic signed [39:0]   xxr_c, yyr_c, xyr_c;
   logic signed [QW-1:0] x4_ff, y4_ff;
   logic                 ovf4_ff;
   logic signed [23:0]   sx2_ff, sy2_ff, sxy_ff;
   logic signed [24:0]   r2_4_ff, r2_4_in;

   assign xxr_c   = xx_ff + 40'sd32768;
   assign yyr_c   = yy_ff + 40'sd32768;
   assign xyr_c   = xy_ff + 40'sd32768;
   assign r2_4_in = 25'($signed(xxr_c[39:16])) + 25'($signed(yyr_c[39:16]));

   // stage 5: r2 squared, k1 term, tangential products
   logic signed [QW-1:0] x5_ff, y5_ff;
   logic                 ovf5_ff;
   logic signed [24:0]   r2_5_ff;
   logic signed [25:0]   tsx_c, tsy_c;
   logic signed [49:0]   r2sq_ff, r2sq_in;
   logic signed [44:0]   k1r2_5_ff, k1r2_in;
   logic signed [43:0]   pxa_ff, pyb_ff, pxa_in, pyb_in;
   logic signed [45:0]   pxb_ff, pya_ff, pxb_in, pya_in;

   assign tsx_c   = 26'(r2_4_ff) + (26'(sx2_ff) <<< 1);
   assign tsy_c   = 26'(r2_4_ff) + (26'(sy2_ff) <<< 1);
   assign r2sq_in = r2_4_ff * r2_4_ff;
   assign k1r2_in = k1_ff * r2_4_ff;
   assign pxa_in  = p1_ff * sxy_ff;
   assign pxb_in  = p2_ff * tsx_c;
   assign pya_in  = p1_ff * tsy_c;
   assign pyb_in  = p2_ff * sxy_ff;

   // stage 6: r4, tangential sums
   logic signed [49:0]   r2sqr_c;
   logic signed [QW-1:0] x6_ff, y6_ff;
   logic                 ovf6_ff;
   logic signed [24:0]   r2_6_ff;
   logic signed [44:0]   k1r2_6_ff;
   logic signed [31:0]   r4_ff, r4_in;
   logic signed [47:0]   tx6_ff, ty6_ff, tx_in, ty_in;

   assign r2sqr_c = r2sq_ff + 50'sd32768;
   assign r4_in   = $signed(r2sqr_c[47:16]);
   assign tx_in   = (48'(pxa_ff) <<< 1) + 48'(pxb_ff);
   assign ty_in   = 48'(pya_ff) + (48'(pyb_ff) <<< 1);

   // stage 7: r4 * r2, k2 term
   logic signed [QW-1:0] x7_ff, y7_ff;
   logic                 ovf7_ff;
   logic signed [44:0]   k1r2_7_ff;
   logic signed [47:0]   tx7_ff, ty7_ff;
   logic signed [56:0]   r4r2_ff, r4r2_in;
   logic signed [51:0]   k2r4_7_ff, k2r4_in;

   assign r4r2_in = r4_ff * r2_6_ff;
   assign k2r4_in = k2_ff * r4_ff;

   // stage 8: r6
   logic signed [56:0]   r4r2r_c;
   logic signed [QW-1:0] x8_ff, y8_ff;
   logic                 ovf8_ff;
   logic signed [44:0]   k1r2_8_ff;
   logic signed [51:0]   k2r4_8_ff;
   logic signed [47:0]   tx8_ff, ty8_ff;
   logic signed [39:0]   r6_ff, r6_in;

   assign r4r2r_c = r4r2_ff + 57'sd32768;
   assign r6_in   = $signed(r4r2r_c[55:16]);

   // stage 9: k3 term as two partial products
   logic signed [QW-1:0] x9_ff, y9_ff;
   logic                 ovf9_ff;
   logic signed [44:0]   k1r2_9_ff;
   logic signed [51:0]   k2r4_9_ff;
   logic signed [47:0]   tx9_ff, ty9_ff;
   logic signed [40:0]   k3lo_ff, k3lo_in;
   logic signed [39:0]   k3hi_ff, k3hi_in;

   assign k3lo_in = k3_ff * $signed({1'b0, r6_ff[19:0]});
   assign k3hi_in = k3_ff * $signed(r6_ff[39:20]);

   // stage 10: radial factor
   logic signed [63:0]   poly_c;
   logic signed [QW-1:0] x10_ff, y10_ff;
   logic                 ovf10_ff;
   logic signed [47:0]   tx10_ff, ty10_ff;
   logic signed [42:0]   fac_ff, fac_in;

   // rounding half is folded into the constant term
   assign poly_c = 64'sh0000_0001_0000_8000 + 64'(k1r2_9_ff) + 64'(k2r4_9_ff)
                 + (64'(k3hi_ff) <<< 20) + 64'(k3lo_ff);
   assign fac_in = $signed(poly_c[58:16]);

   // stage 11: coordinate times factor, split in two
   logic                 ovf11_ff;
   logic signed [47:0]   tx11_ff, ty11_ff;
   logic signed [41:0]   xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic signed [41:0]   xlo_in, xhi_in, ylo_in, yhi_in;

   assign xlo_in = x10_ff * $signed({1'b0, fac_ff[20:0]});
   assign xhi_in = x10_ff * $signed(fac_ff[42:21]);
   assign ylo_in = y10_ff * $signed({1'b0, fac_ff[20:0]});
   assign yhi_in = y10_ff * $signed(fac_ff[42:21]);

   // stage 12: final sums, round, saturate
   logic signed [63:0] sumx_c, sumy_c;
   logic [QW:0]        ox_c, oy_c;

   assign sumx_c = (64'(xhi_ff) <<< 21) + 64'(xlo_ff) + 64'(tx11_ff) + 64'sd32768;
   assign sumy_c = (64'(yhi_ff) <<< 21) + 64'(ylo_ff) + 64'(ty11_ff) + 64'sd32768;
   assign ox_c   = sat_q($signed(sumx_c[63:16]));
   assign oy_c   = sat_q($signed(sumy_c[63:16]));

   always_comb begin
      out_in.norm_x   = ox_c[QW-1:0];
      out_in.norm_y   = oy_c[QW-1:0];
      out_in.overflow = ovf11_ff | ox_c[QW] | oy_c[QW];
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff     <= mx_in;
         my_ff     <= my_in;

         x2_ff     <= satx_c[QW-1:0];
         y2_ff     <= saty_c[QW-1:0];
         ovf2_ff   <= ovf2_in;

         x3_ff     <= x2_ff;
         y3_ff     <= y2_ff;
         ovf3_ff   <= ovf2_ff;
         xx_ff     <= xx_in;
         yy_ff     <= yy_in;
         xy_ff     <= xy_in;

         x4_ff     <= x3_ff;
         y4_ff     <= y3_ff;
         ovf4_ff   <= ovf3_ff;
         sx2_ff    <= $signed(xxr_c[39:16]);
         sy2_ff    <= $signed(yyr_c[39:16]);
         sxy_ff    <= $signed(xyr_c[39:16]);
         r2_4_ff   <= r2_4_in;

         x5_ff     <= x4_ff;
         y5_ff     <= y4_ff;
         ovf5_ff   <= ovf4_ff;
         r2_5_ff   <= r2_4_ff;
         r2sq_ff   <= r2sq_in;
         k1r2_5_ff <= k1r2_in;
         pxa_ff    <= pxa_in;
         pxb_ff    <= pxb_in;
         pya_ff    <= pya_in;
         pyb_ff    <= pyb_in;

         x6_ff     <= x5_ff;
         y6_ff     <= y5_ff;
         ovf6_ff   <= ovf5_ff;
         r2_6_ff   <= r2_5_ff;
         k1r2_6_ff <= k1r2_5_ff;
         r4_ff     <= r4_in;
         tx6_ff    <= tx_in;
         ty6_ff    <= ty_in;

         x7_ff     <= x6_ff;
         y7_ff     <= y6_ff;
         ovf7_ff   <= ovf6_ff;
         k1r2_7_ff <= k1r2_6_ff;
         tx7_ff    <= tx6_ff;
         ty7_ff    <= ty6_ff;
         r4r2_ff   <= r4r2_in;
         k2r4_7_ff <= k2r4_in;

         x8_ff     <= x7_ff;
         y8_ff     <= y7_ff;
         ovf8_ff   <= ovf7_ff;
         k1r2_8_ff <= k1r2_7_ff;
         k2r4_8_ff <= k2r4_7_ff;
         tx8_ff    <= tx7_ff;
         ty8_ff    <= ty7_ff;
         r6_ff     <= r6_in;

         x9_ff     <= x8_ff;
         y9_ff     <= y8_ff;
         ovf9_ff   <= ovf8_ff;
         k1r2_9_ff <= k1r2_8_ff;
         k2r4_9_ff <= k2r4_8_ff;
         tx9_ff    <= tx8_ff;
         ty9_ff    <= ty8_ff;
         k3lo_ff   <= k3lo_in;
         k3hi_ff   <= k3hi_in;

         x10_ff    <= x9_ff;
         y10_ff    <= y9_ff;
         ovf10_ff  <= ovf9_ff;
         tx10_ff   <= tx9_ff;
         ty10_ff   <= ty9_ff;
         fac_ff    <= fac_in;

         ovf11_ff  <= ovf10_ff;
         tx11_ff   <= tx10_ff;
         ty11_ff   <= ty10_ff;
         xlo_ff    <= xlo_in;
         xhi_ff    <= xhi_in;
         ylo_ff    <= ylo_in;
         yhi_ff    <= yhi_in;

         out_ff    <= out_in;
      end
   end

   `ASSERT_STD(a_skid_from_last, $rose(skid_vld_ff) |-> $past(vld_ff[STAGES-1] && rsp_stall))
   `ASSERT_STD(a_hold_while_full, skid_vld_ff |=> $stable(vld_ff))
   `ASSERT_STD(a_accept_enters, req_valid && !req_stall |=> vld_ff[0])

endmodule

### tb/lens_distortion_model_tb.sv
module lens_distortion_model_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ldm_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 1000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned REPORT_MAX   = 10;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ldm_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ldm_rsp_type rsp_data;
   logic        csr_we    = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // shadow copy of the coefficient registers
   logic [31:0]        center_reg = '0;
   logic [23:0]        inv_fx_reg = INV_FOCAL_RESET;
   logic [23:0]        inv_fy_reg = INV_FOCAL_RESET;
   logic signed [19:0] k1_reg = '0;
   logic signed [19:0] k2_reg = '0;
   logic signed [19:0] k3_reg = '0;
   logic signed [19:0] p1_reg = '0;
   logic signed [19:0] p2_reg = '0;

   ldm_req_type point_q[$];
   ldm_rsp_type corrected_q[$];

   int unsigned mismatches     = 0;
   int unsigned requests_sent  = 0;
   int unsigned results_seen   = 0;
   int unsigned saturated_seen = 0;
   int unsigned settings_used  = 0;

   lens_distortion_model dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint round_half_up(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint saturate_q(longint v, inout bit clipped);
      if (v > longint'(Q_MAX)) begin
         clipped = 1'b1;
         return longint'(Q_MAX);
      end
      if (v < longint'(Q_MIN)) begin
         clipped = 1'b1;
         return longint'(Q_MIN);
      end
      return v;
   endfunction

   function automatic ldm_rsp_type distort_point(ldm_req_type p);
      bit          clipped;
      longint      dx, dy, x, y, x2, y2, xy, r2, r4, r6, poly, factor, sx, sy, ox, oy;
      ldm_rsp_type r;
      clipped = 1'b0;
      dx = longint'(p.pixel_x) - longint'(center_reg[15:0]);
      dy = longint'(p.pixel_y) - longint'(center_reg[31:16]);
      x  = saturate_q(round_half_up(dx * longint'(inv_fx_reg), 12), clipped);
      y  = saturate_q(round_half_up(dy * longint'(inv_fy_reg), 12), clipped);
      x2 = round_half_up(x * x, 16);
      y2 = round_half_up(y * y, 16);
      xy = round_half_up(x * y, 16);
      r2 = x2 + y2;
      r4 = round_half_up(r2 * r2, 16);
      r6 = round_half_up(r4 * r2, 16);
      poly = (longint'(1) << 32) + longint'(k1_reg) * r2 + longint'(k2_reg) * r4
             + longint'(k3_reg) * r6;
      factor = round_half_up(poly, 16);
      sx = x * factor + 2 * longint'(p1_reg) * xy + longint'(p2_reg) * (r2 + 2 * x2);
      sy = y * factor + longint'(p1_reg) * (r2 + 2 * y2) + 2 * longint'(p2_reg) * xy;
      ox = saturate_q(round_half_up(sx, 16), clipped);
      oy = saturate_q(round_half_up(sy, 16), clipped);
      r.norm_x   = ox[19:0];
      r.norm_y   = oy[19:0];
      r.overflow = clipped;
      return r;
   endfunction

   // mostly short pauses, now and then a long one
   function automatic int unsigned pick_pause();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [23:0] pick_focal();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 12) return 24'($urandom_range(1, 24'hFFFFFF));
      if (r < 15) return 24'd0;
      if (r < 18) return 24'hFFFFFF;
      return 24'($urandom_range(8000, 120000));
   endfunction

   function automatic logic signed [19:0] pick_coeff();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 20'($urandom_range(0, 65536) - 32768);
      if (r < 75) return '0;
      if (r < 90) return 20'($urandom);
      if (r < 95) return Q_MAX;
      return Q_MIN;
   endfunction

   task automatic write_csr(ldm_csr_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CENTER: center_reg = val;
         CSR_INV_FX: inv_fx_reg = val[23:0];
         CSR_INV_FY: inv_fy_reg = val[23:0];
         CSR_K1:     k1_reg = val[19:0];
         CSR_K2:     k2_reg = val[19:0];
         CSR_K3:     k3_reg = val[19:0];
         CSR_P1:     p1_reg = val[19:0];
         CSR_P2:     p2_reg = val[19:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(logic [31:0] centre, logic [23:0] fx, logic [23:0] fy,
                                 logic signed [19:0] k1, logic signed [19:0] k2,
                                 logic signed [19:0] k3, logic signed [19:0] p1,
                                 logic signed [19:0] p2);
      write_csr(CSR_CENTER, centre);
      write_csr(CSR_INV_FX, {8'h00, fx});
      write_csr(CSR_INV_FY, {8'h00, fy});
      write_csr(CSR_K1, 32'(k1));
      write_csr(CSR_K2, 32'(k2));
      write_csr(CSR_K3, 32'(k3));
      write_csr(CSR_P1, 32'(p1));
      write_csr(CSR_P2, 32'(p2));
      settings_used++;
   endtask

   task automatic push_point(logic [15:0] px, logic [15:0] py);
      point_q.push_back('{pixel_x: px, pixel_y: py});
   endtask

   task automatic wait_idle();
      while (point_q.size() != 0 || corrected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] centre;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values: focal length of 400 pixels, zero centre, corners away from the origin saturate
      push_point(16'h0000, 16'h0000);
      push_point(16'hFFFF, 16'hFFFF);
      push_point(16'hFFFF, 16'h0000);
      push_point(16'h0000, 16'hFFFF);
      push_point(16'h1234, 16'h0ABC);
      push_point(16'h8000, 16'h7FFF);
      wait_idle();

      // typical camera: centre 640,360, barrel distortion
      apply_settings(32'h1680_2800, 24'd20972, 24'd21237, -20'sd18350, 20'sd5243,
                     -20'sd655, 20'sd66, -20'sd33);
      push_point(16'h2800, 16'h1680);
      push_point(16'h2801, 16'h1680);
      push_point(16'h27FF, 16'h167F);
      push_point(16'h0000, 16'h0000);
      push_point(16'h5000, 16'h2D00);
      push_point(16'hFFFF, 16'hFFFF);
      wait_idle();

      // zero reciprocal focal length on x, largest on y, coefficients at maximum
      apply_settings(32'h8000_8000, 24'd0, 24'hFFFFFF, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      push_point(16'h1234, 16'h8000);
      push_point(16'h0000, 16'h8001);
      push_point(16'hFFFF, 16'h7FFF);
      push_point(16'h8000, 16'h8010);
      wait_idle();

      // centre at the far corner, coefficients at minimum
      apply_settings(32'hFFFF_FFFF, 24'd167772, 24'd167772, Q_MIN, Q_MIN, Q_MIN,
                     Q_MIN, Q_MIN);
      push_point(16'h0000, 16'h0000);
      push_point(16'hFFFF, 16'hFFFF);
      push_point(16'hF000, 16'hFFF0);
      push_point(16'hFFF0, 16'hF000);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         if ($urandom_range(0, 99) < 70)
            centre = {16'($urandom_range(0, 16'h3000)), 16'($urandom_range(0, 16'h5000))};
         else
            centre = $urandom;
         apply_settings(centre, pick_focal(), pick_focal(), pick_coeff(), pick_coeff(),
                        pick_coeff(), pick_coeff(), pick_coeff());
         repeat (200) begin
            // most points anywhere, some clustered near the optical centre
            if ($urandom_range(0, 99) < 70)
               push_point(16'($urandom), 16'($urandom));
            else
               push_point(center_reg[15:0] + 16'($urandom_range(0, 4095)) - 16'd2048,
                          center_reg[31:16] + 16'($urandom_range(0, 4095)) - 16'd2048);
         end
         wait_idle();
      end

      $display("covered %0d requests and %0d results over %0d register settings",
               requests_sent, results_seen, settings_used + 1);
      $display("%0d results saturated, %0d mismatches", saturated_seen, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // request driver
   int unsigned gap_left   = 0;
   int unsigned burst_left = 0;

   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            corrected_q.push_back(distort_point(req_data));
            void'(point_q.pop_front());
            requests_sent++;
            offer = 1'b0;
            if (burst_left > 0) begin
               burst_left--;
               gap_left = 0;
            end else if ($urandom_range(0, 99) < 2) begin
               burst_left = $urandom_range(40, 160);
               gap_left   = 0;
            end else begin
               gap_left = pick_pause();
            end
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (point_q.size() != 0) begin
               req_data <= point_q[0];
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // result monitor and stall pattern
   int unsigned stall_left = 0;
   int unsigned calm_left  = 0;

   always @(posedge clock) begin
      ldm_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_data.overflow) saturated_seen++;
            if (corrected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected result x %0d y %0d ovf %0b with nothing pending",
                           rsp_data.norm_x, rsp_data.norm_y, rsp_data.overflow);
            end else begin
               want = corrected_q.pop_front();
               if (rsp_data.norm_x !== want.norm_x || rsp_data.norm_y !== want.norm_y ||
                   rsp_data.overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("result %0d: expected x %0d y %0d ovf %0b, got x %0d y %0d ovf %0b",
                              results_seen, want.norm_x, want.norm_y, want.overflow,
                              rsp_data.norm_x, rsp_data.norm_y, rsp_data.overflow);
               end
            end
         end
         if (stall_left > 0)
            stall_left--;
         else if (calm_left > 0)
            calm_left--;
         else if ($urandom_range(0, 99) < 3)
            calm_left = $urandom_range(30, 150);
         else if ($urandom_range(0, 99) < 30)
            stall_left = pick_pause();
         rsp_stall <= (stall_left > 0);
      end
   end

   // watchdog on cycles where neither channel moves
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, corrected_q.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule
